>>> design/limit_order_book_unit_defines.svh
// Assertion macros for the limit order book unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef LIMIT_ORDER_BOOK_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_UNIT_DEFINES_SVH
`ifndef SYNTH
`define LOB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lob assertion failed");
`define LOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lob assertion failed");
`else
`define LOB_ASSERT(lbl, clk, rst_n, prop)
`define LOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/lob_pkg.sv
// Shared constants and types for the limit order book unit.
// No dependencies.
`timescale 1ns / 1ps
package lob_pkg;
    localparam int MAX_ORDERS = 256;
    localparam int IDX_W = $clog2(MAX_ORDERS);
    localparam int CNT_W = $clog2(MAX_ORDERS + 1);

    localparam logic [2:0] F_ADD     = 3'd0;
    localparam logic [2:0] F_CANCEL  = 3'd1;
    localparam logic [2:0] F_REPLACE = 3'd2;
    localparam logic [2:0] F_POP     = 3'd3;
    localparam logic [2:0] F_DEPTH   = 3'd4;
    localparam logic [2:0] F_CLEAR   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_DUP      = 2'd3;

    typedef struct packed {
        logic        is_ask;
        logic [63:0] id;
        logic [30:0] price;
        logic [23:0] qty;
        logic [63:0] arrival;
    } t_slot;

    typedef struct packed {
        logic             have;
        logic [IDX_W-1:0] idx;
        logic [30:0]      price;
        logic [63:0]      arrival;
        logic [63:0]      id;
        logic [23:0]      qty;
    } t_best;

    function automatic logic better(input t_best cur, input logic ask,
                                    input logic [30:0] price, input logic [63:0] arr);
        logic r;
        r = !cur.have
            || (ask ? (price < cur.price) : (price > cur.price))
            || (price == cur.price && arr < cur.arrival);
        return r;
    endfunction
endpackage

>>> design/limit_order_book_unit.sv
// Limit order book unit: price-time priority book over a pool of order slots.
// Depends on lob_pkg and limit_order_book_unit_defines.svh.
//
// Usage: drive the operation fields and raise start; the operation is taken
// at a clock edge where start is high and busy is low. busy then stays high
// while a sequencer walks the slot memory, one slot per cycle, through one
// shared compare and accumulate datapath (best price search, id match, free
// slot search and depth sum). The result beat appears on the o_ result ports
// for exactly one cycle with o_strobe high, and busy is low in that cycle, so
// the next operation may start at once. The receiver cannot stall.
// Add, depth query, unused codes and any operation that removes no order
// make one pass over the slots; a cancel, replace or pop that removes an
// order takes one more slot pass; clear makes no slot pass. The slot memory
// read port reads one slot per cycle.
// Reset (synchronous, active low) empties the book and zeroes the arrival
// counter; it needs no clearing pass.
`timescale 1ns / 1ps
`include "limit_order_book_unit_defines.svh"
module limit_order_book_unit import lob_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_func,
    input  logic               i_side,
    input  logic [63:0]        i_order_id,
    input  logic [63:0]        i_old_id,
    input  logic [30:0]        i_price,
    input  logic [23:0]        i_quantity,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_best_bid,
    output logic signed [31:0] o_best_ask,
    output logic [63:0]        o_top_bid_id,
    output logic [23:0]        o_top_bid_qty,
    output logic [63:0]        o_top_ask_id,
    output logic [23:0]        o_top_ask_qty,
    output logic [30:0]        o_depth_total
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_ORDERS);

    logic [2:0]             r_state;
    logic [MAX_ORDERS-1:0]  r_valid;
    logic [63:0]            r_arr;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_pv;
    logic [IDX_W-1:0]       r_pidx;
    logic                   r_strobe;

    logic [2:0]             r_func;
    logic                   r_side;
    logic [63:0]            r_id;
    logic [63:0]            r_old;
    logic [30:0]            r_price;
    logic [23:0]            r_qty;

    logic                   r_mfound;
    logic [IDX_W-1:0]       r_midx;
    logic                   r_ffound;
    logic [IDX_W-1:0]       r_fidx;
    logic                   r_dup;
    logic [30:0]            r_sum;
    logic [1:0]             r_status;
    t_best                  r_bst [2];

    t_slot                  r_mem [MAX_ORDERS];
    t_slot                  r_rd;

    logic [1:0]             r_o_status;
    logic [31:0]            r_o_bid;
    logic [31:0]            r_o_ask;
    logic [63:0]            r_o_bid_id;
    logic [23:0]            r_o_bid_qty;
    logic [63:0]            r_o_ask_id;
    logic [23:0]            r_o_ask_qty;
    logic [30:0]            r_o_depth;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    t_slot                  mem_wdata;
    logic                   live;
    logic [63:0]            key;
    logic                   depth_hit;
    logic [31:0]            sum_ext;
    t_best                  cand;
    t_best                  new_best;
    logic [IDX_W-1:0]       rep_idx;

    always_comb begin
        live      = r_pv && r_valid[r_pidx];
        key       = (r_func == F_REPLACE) ? r_old : r_id;
        depth_hit = live && (r_func == F_DEPTH) && (r_rd.is_ask == r_side)
                    && (r_side ? (r_rd.price <= r_price) : (r_rd.price >= r_price));
        sum_ext   = {1'b0, r_sum} + {8'd0, r_rd.qty};
        cand      = '{have: 1'b1, idx: r_pidx, price: r_rd.price,
                      arrival: r_rd.arrival, id: r_rd.id, qty: r_rd.qty};
        rep_idx   = (r_ffound && r_fidx < r_midx) ? r_fidx : r_midx;
        mem_wdata = '{is_ask: r_side, id: r_id, price: r_price, qty: r_qty,
                      arrival: r_arr};
        mem_we    = 1'b0;
        mem_waddr = r_fidx;
        if (r_state == S_APPLY) begin
            if (r_func == F_ADD && !r_mfound && r_ffound) begin
                mem_we = 1'b1;
            end else if (r_func == F_REPLACE && r_mfound && !r_dup) begin
                mem_we    = 1'b1;
                mem_waddr = rep_idx;
            end
        end
        new_best  = '{have: 1'b1, idx: mem_waddr, price: r_price, arrival: r_arr,
                      id: r_id, qty: r_qty};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_arr    <= '0;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func   <= i_func;
                        r_side   <= i_side;
                        r_id     <= i_order_id;
                        r_old    <= i_old_id;
                        r_price  <= i_price;
                        r_qty    <= i_quantity;
                        r_cnt    <= '0;
                        r_pv     <= 1'b0;
                        r_mfound <= 1'b0;
                        r_ffound <= 1'b0;
                        r_dup    <= 1'b0;
                        r_sum    <= '0;
                        r_status <= ST_OK;
                        r_bst[0].have <= 1'b0;
                        r_bst[1].have <= 1'b0;
                        r_state  <= (i_func == F_CLEAR) ? S_APPLY : S_SCAN1;
                    end
                end
                S_SCAN1, S_SCAN2: begin
                    if (r_cnt != CNT_END) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_pv   <= (r_cnt != CNT_END);
                    r_pidx <= r_cnt[IDX_W-1:0];
                    if (live && better(r_bst[r_rd.is_ask], r_rd.is_ask,
                                       r_rd.price, r_rd.arrival)) begin
                        r_bst[r_rd.is_ask] <= cand;
                    end
                    if (r_state == S_SCAN1 && r_pv) begin
                        if (!r_valid[r_pidx] && !r_ffound) begin
                            r_ffound <= 1'b1;
                            r_fidx   <= r_pidx;
                        end
                        if (live && r_rd.id == key && !r_mfound) begin
                            r_mfound <= 1'b1;
                            r_midx   <= r_pidx;
                        end
                        if (live && r_rd.id == r_id && r_rd.id != r_old) begin
                            r_dup <= 1'b1;
                        end
                        if (depth_hit) begin
                            r_sum <= sum_ext[31] ? '1 : sum_ext[30:0];
                        end
                    end
                    if (r_cnt == CNT_END && !r_pv) begin
                        r_state <= (r_state == S_SCAN1) ? S_APPLY : S_OUT;
                    end
                end
                S_APPLY: begin
                    r_cnt   <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_OUT;
                    unique case (r_func)
                        F_ADD: begin
                            if (r_mfound) begin
                                r_status <= ST_DUP;
                            end else if (!r_ffound) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_valid[r_fidx] <= 1'b1;
                                r_arr <= r_arr + 64'd1;
                                if (better(r_bst[r_side], r_side, r_price, r_arr)) begin
                                    r_bst[r_side] <= new_best;
                                end
                            end
                        end
                        F_CANCEL: begin
                            if (!r_mfound) begin
                                r_status <= ST_NOTFOUND;
                            end else begin
                                r_valid[r_midx] <= 1'b0;
                                r_bst[0].have <= 1'b0;
                                r_bst[1].have <= 1'b0;
                                r_state <= S_SCAN2;
                            end
                        end
                        F_REPLACE: begin
                            if (!r_mfound) begin
                                r_status <= ST_NOTFOUND;
                            end else begin
                                r_valid[r_midx] <= 1'b0;
                                if (r_dup) begin
                                    r_status <= ST_DUP;
                                end else begin
                                    r_valid[rep_idx] <= 1'b1;
                                    r_arr <= r_arr + 64'd1;
                                end
                                r_bst[0].have <= 1'b0;
                                r_bst[1].have <= 1'b0;
                                r_state <= S_SCAN2;
                            end
                        end
                        F_POP: begin
                            if (r_bst[r_side].have) begin
                                r_valid[r_bst[r_side].idx] <= 1'b0;
                                r_bst[0].have <= 1'b0;
                                r_bst[1].have <= 1'b0;
                                r_state <= S_SCAN2;
                            end
                        end
                        F_CLEAR: begin
                            r_valid <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_OUT: begin
                    r_o_status  <= r_status;
                    r_o_bid     <= r_bst[0].have ? {1'b0, r_bst[0].price} : '1;
                    r_o_ask     <= r_bst[1].have ? {1'b0, r_bst[1].price} : '1;
                    r_o_bid_id  <= r_bst[0].have ? r_bst[0].id : '0;
                    r_o_bid_qty <= r_bst[0].have ? r_bst[0].qty : '0;
                    r_o_ask_id  <= r_bst[1].have ? r_bst[1].id : '0;
                    r_o_ask_qty <= r_bst[1].have ? r_bst[1].qty : '0;
                    r_o_depth   <= r_sum;
                    r_strobe    <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_o_status;
    assign o_best_bid    = r_o_bid;
    assign o_best_ask    = r_o_ask;
    assign o_top_bid_id  = r_o_bid_id;
    assign o_top_bid_qty = r_o_bid_qty;
    assign o_top_ask_id  = r_o_ask_id;
    assign o_top_ask_qty = r_o_ask_qty;
    assign o_depth_total = r_o_depth;

    `LOB_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `LOB_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `LOB_ASSERT(a_strobe_idle, i_clk, i_rst_n, !o_strobe || !busy)
    `LOB_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CNT_END)
    `LOB_ASSERT_NEXT(a_out_strobe, i_clk, i_rst_n, r_state == S_OUT, o_strobe)
endmodule

>>> test/tb_limit_order_book_unit.sv
// Self-checking testbench for limit_order_book_unit: directed table, then random operations.
// Depends on lob_pkg and the RTL; a local price-time book predicts beats the table omits.
`timescale 1ns / 1ps
module tb_limit_order_book_unit import lob_pkg::*; ();

    localparam int  RUN_LIMIT = 4000000;
    localparam int  DRAIN     = 2 * MAX_ORDERS + 40;
    localparam logic [2:0] F_SPARE6 = 3'd6;
    localparam logic [2:0] F_SPARE7 = 3'd7;
    localparam logic [30:0] PRICE_MAX = 31'h7fffffff;
    localparam logic [23:0] QTY_MAX   = 24'hffffff;

    typedef struct packed {
        logic [2:0]  func;
        logic        side;
        logic [63:0] id;
        logic [63:0] old;
        logic [30:0] price;
        logic [23:0] qty;
    } t_op;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] bid;
        logic signed [31:0] ask;
        logic [63:0]        bid_id;
        logic [23:0]        bid_qty;
        logic [63:0]        ask_id;
        logic [23:0]        ask_qty;
        logic [30:0]        depth;
    } t_quote;

    logic i_clk, i_rst_n, start, busy;
    logic [2:0] i_func;
    logic i_side;
    logic [63:0] i_order_id, i_old_id;
    logic [30:0] i_price;
    logic [23:0] i_quantity;
    logic o_strobe;
    logic [1:0] o_status;
    logic signed [31:0] o_best_bid, o_best_ask;
    logic [63:0] o_top_bid_id, o_top_ask_id;
    logic [23:0] o_top_bid_qty, o_top_ask_qty;
    logic [30:0] o_depth_total;

    limit_order_book_unit uut (.*);

    bit          book_live [MAX_ORDERS];
    bit          book_ask  [MAX_ORDERS];
    logic [63:0] book_id   [MAX_ORDERS];
    logic [30:0] book_price[MAX_ORDERS];
    logic [23:0] book_qty  [MAX_ORDERS];
    logic [63:0] book_stamp[MAX_ORDERS];
    logic [63:0] next_stamp;

    t_quote quote_q[$];
    int     errors, cycles, beats_seen, full_seen, dup_seen, miss_seen, sat_seen;
    int     func_seen[8];

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int find_order(input logic [63:0] id);
        for (int i = 0; i < MAX_ORDERS; i++)
            if (book_live[i] && book_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int best_order(input bit ask);
        int b;
        b = -1;
        for (int i = 0; i < MAX_ORDERS; i++) begin
            if (!book_live[i] || book_ask[i] != ask) continue;
            if (b < 0) b = i;
            else if (book_price[i] == book_price[b]) begin
                if (book_stamp[i] < book_stamp[b]) b = i;
            end else if (ask ? book_price[i] < book_price[b] : book_price[i] > book_price[b])
                b = i;
        end
        return b;
    endfunction

    function automatic logic [1:0] rest_order(input t_op op);
        if (find_order(op.id) >= 0) return ST_DUP;
        for (int i = 0; i < MAX_ORDERS; i++) begin
            if (!book_live[i]) begin
                book_live[i]  = 1'b1;
                book_ask[i]   = op.side;
                book_id[i]    = op.id;
                book_price[i] = op.price;
                book_qty[i]   = op.qty;
                book_stamp[i] = next_stamp;
                next_stamp    = next_stamp + 64'd1;
                return ST_OK;
            end
        end
        return ST_FULL;
    endfunction

    function automatic t_quote apply_op(input t_op op);
        t_quote r;
        int s, b, a;
        longint unsigned sum;
        r = '0;
        sum = 0;
        case (op.func)
            F_ADD: r.status = rest_order(op);
            F_CANCEL: begin
                s = find_order(op.id);
                if (s < 0) r.status = ST_NOTFOUND;
                else book_live[s] = 1'b0;
            end
            F_REPLACE: begin
                s = find_order(op.old);
                if (s < 0) r.status = ST_NOTFOUND;
                else begin
                    book_live[s] = 1'b0;
                    r.status = rest_order(op);
                end
            end
            F_POP: begin
                s = best_order(op.side);
                if (s >= 0) book_live[s] = 1'b0;
            end
            F_DEPTH: begin
                for (int i = 0; i < MAX_ORDERS; i++)
                    if (book_live[i] && book_ask[i] == op.side
                        && (op.side ? book_price[i] <= op.price : book_price[i] >= op.price))
                        sum += book_qty[i];
                r.depth = (sum > PRICE_MAX) ? PRICE_MAX : sum[30:0];
                if (sum > PRICE_MAX) sat_seen++;
            end
            F_CLEAR: for (int i = 0; i < MAX_ORDERS; i++) book_live[i] = 1'b0;
            default: ;
        endcase
        b = best_order(1'b0);
        a = best_order(1'b1);
        r.bid     = (b < 0) ? -32'sd1 : $signed({1'b0, book_price[b]});
        r.ask     = (a < 0) ? -32'sd1 : $signed({1'b0, book_price[a]});
        r.bid_id  = (b < 0) ? 64'd0 : book_id[b];
        r.bid_qty = (b < 0) ? 24'd0 : book_qty[b];
        r.ask_id  = (a < 0) ? 64'd0 : book_id[a];
        r.ask_qty = (a < 0) ? 24'd0 : book_qty[a];
        return r;
    endfunction

    function automatic logic [63:0] rand_id();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] live_or_random(input int pct_live);
        int k;
        if ($urandom_range(99) < pct_live) begin
            k = $urandom_range(MAX_ORDERS - 1);
            for (int i = 0; i < MAX_ORDERS; i++)
                if (book_live[(k + i) % MAX_ORDERS]) return book_id[(k + i) % MAX_ORDERS];
        end
        return rand_id();
    endfunction

    function automatic t_op random_op(input bit fill);
        t_op op;
        int w;
        op.side  = 1'($urandom_range(1));
        op.id    = ($urandom_range(99) < 8) ? live_or_random(100) : rand_id();
        op.old   = live_or_random(85);
        op.price = ($urandom_range(99) < 20) ? 31'($urandom())
                                             : 31'($urandom_range(90, 110));
        op.qty   = ($urandom_range(99) < 25) ? QTY_MAX : 24'($urandom());
        w = fill ? 0 : $urandom_range(999);
        if (w < 550) op.func = F_ADD;
        else if (w < 650) begin
            op.func = F_CANCEL;
            op.id   = live_or_random(80);
        end else if (w < 760) op.func = F_REPLACE;
        else if (w < 850) op.func = F_POP;
        else if (w < 985) op.func = F_DEPTH;
        else if (w < 990) op.func = F_CLEAR;
        else op.func = $urandom_range(1) ? F_SPARE6 : F_SPARE7;
        return op;
    endfunction

    task automatic issue(input t_op op, input bit typed, input t_quote want,
                         input int idle_pct);
        t_quote pred;
        i_func     <= op.func;
        i_side     <= op.side;
        i_order_id <= op.id;
        i_old_id   <= op.old;
        i_price    <= op.price;
        i_quantity <= op.qty;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        pred = apply_op(op);
        quote_q.push_back(typed ? want : pred);
        func_seen[op.func]++;
        if (pred.status == ST_FULL) full_seen++;
        if (pred.status == ST_DUP) dup_seen++;
        if (pred.status == ST_NOTFOUND) miss_seen++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic hold_until_empty();
        start <= 1'b0;
        while (quote_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on %s at beat %0d: expected %h, got %h", name, beats_seen, e, a);
        end
    endtask

    always @(posedge i_clk) begin
        t_quote e;
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
        if (i_rst_n && o_strobe) begin
            if (quote_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result beat with nothing expected");
            end else begin
                e = quote_q[0];
                quote_q.delete(0);
                check_field("status", 64'(e.status), 64'(o_status));
                check_field("best_bid", 64'(unsigned'(e.bid)), 64'(unsigned'(o_best_bid)));
                check_field("best_ask", 64'(unsigned'(e.ask)), 64'(unsigned'(o_best_ask)));
                check_field("top_bid_id", e.bid_id, o_top_bid_id);
                check_field("top_bid_qty", 64'(e.bid_qty), 64'(o_top_bid_qty));
                check_field("top_ask_id", e.ask_id, o_top_ask_id);
                check_field("top_ask_qty", 64'(e.ask_qty), 64'(o_top_ask_qty));
                check_field("depth_total", 64'(e.depth), 64'(o_depth_total));
            end
            beats_seen++;
        end
    end

    t_op    dir_op[$];
    bit     dir_typed[$];
    t_quote dir_want[$];

    task automatic row(input logic [2:0] f, input logic s, input logic [63:0] id,
                       input logic [63:0] old, input logic [30:0] p, input logic [23:0] q,
                       input bit typed, input t_quote w);
        dir_op.push_back(t_op'{f, s, id, old, p, q});
        dir_typed.push_back(typed);
        dir_want.push_back(w);
    endtask

    initial begin
        t_quote none, w;
        int idle_pct;
        full_seen = 0;
        dup_seen = 0;
        miss_seen = 0;
        sat_seen = 0;
        next_stamp = '0;
        for (int i = 0; i < MAX_ORDERS; i++) book_live[i] = 1'b0;
        for (int i = 0; i < 8; i++) func_seen[i] = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_func     <= F_ADD;
        i_side     <= 1'b0;
        i_order_id <= '0;
        i_old_id   <= '0;
        i_price    <= '0;
        i_quantity <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        none = '{ST_OK, -32'sd1, -32'sd1, 64'd0, 24'd0, 64'd0, 24'd0, 31'd0};
        row(F_POP, 1'b0, 64'd0, 64'd0, 31'd0, 24'd0, 1'b1, none);
        w = none;
        w.status = ST_NOTFOUND;
        row(F_CANCEL, 1'b0, 64'd5, 64'd0, 31'd0, 24'd0, 1'b1, w);
        w = none;
        w.bid = 32'sd0;
        row(F_ADD, 1'b0, 64'd0, 64'd0, 31'd0, 24'd0, 1'b1, w);
        w.ask = 32'sh7fffffff;
        w.ask_id = '1;
        w.ask_qty = QTY_MAX;
        row(F_ADD, 1'b1, '1, 64'd0, PRICE_MAX, QTY_MAX, 1'b1, w);
        w.bid = 32'sh7fffffff;
        w.bid_id = 64'd1;
        w.bid_qty = QTY_MAX;
        row(F_ADD, 1'b0, 64'd1, 64'd0, PRICE_MAX, QTY_MAX, 1'b1, w);
        w.status = ST_DUP;
        row(F_ADD, 1'b0, 64'd1, 64'd0, 31'd7, 24'd3, 1'b1, w);
        row(F_ADD, 1'b1, 64'd2, 64'd0, 31'd100, 24'd10, 1'b0, none);
        row(F_ADD, 1'b1, 64'd3, 64'd0, 31'd100, 24'd20, 1'b0, none);
        row(F_DEPTH, 1'b1, 64'd0, 64'd0, 31'd100, 24'd0, 1'b0, none);
        row(F_DEPTH, 1'b0, 64'd0, 64'd0, 31'd0, 24'd0, 1'b0, none);
        row(F_REPLACE, 1'b0, 64'd4, 64'd2, 31'd50, 24'd7, 1'b0, none);
        row(F_REPLACE, 1'b1, 64'd9, 64'd99, 31'd50, 24'd7, 1'b0, none);
        row(F_REPLACE, 1'b1, 64'd1, 64'd3, 31'd60, 24'd8, 1'b0, none);
        row(F_POP, 1'b1, 64'd0, 64'd0, 31'd0, 24'd0, 1'b0, none);
        row(F_POP, 1'b0, 64'd0, 64'd0, 31'd0, 24'd0, 1'b0, none);
        row(F_SPARE6, 1'b1, '1, '1, PRICE_MAX, QTY_MAX, 1'b0, none);
        row(F_SPARE7, 1'b0, 64'd0, 64'd0, 31'd0, 24'd0, 1'b0, none);
        row(F_CLEAR, 1'b0, 64'd0, 64'd0, 31'd0, 24'd0, 1'b1, none);
        row(F_ADD, 1'b1, 64'd1, 64'd0, 31'd200, 24'd5, 1'b0, none);
        row(F_ADD, 1'b0, 64'd5, 64'd0, PRICE_MAX, QTY_MAX, 1'b0, none);
        row(F_ADD, 1'b0, 64'd6, 64'd0, PRICE_MAX, QTY_MAX, 1'b0, none);
        row(F_DEPTH, 1'b0, 64'd0, 64'd0, 31'd0, 24'd0, 1'b0, none);
        row(F_DEPTH, 1'b1, 64'd0, 64'd0, PRICE_MAX, 24'd0, 1'b0, none);
        for (int i = 0; i < dir_op.size(); i++)
            issue(dir_op[i], dir_typed[i], dir_want[i], 0);
        hold_until_empty();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 7 : (phase == 1) ? 54 : 0;
            if (phase == 1)
                for (int i = 0; i < MAX_ORDERS + 4; i++)
                    issue(random_op(1'b1), 1'b0, none, idle_pct);
            for (int i = 0; i < ((phase == 1) ? 90 : 350); i++)
                issue(random_op(1'b0), 1'b0, none, idle_pct);
            hold_until_empty();
        end

        repeat (DRAIN) @(posedge i_clk);
        $display("covered %0d beats: add %0d cancel %0d replace %0d pop %0d depth %0d clear %0d",
                 beats_seen, func_seen[F_ADD], func_seen[F_CANCEL], func_seen[F_REPLACE],
                 func_seen[F_POP], func_seen[F_DEPTH], func_seen[F_CLEAR]);
        $display("book full %0d, duplicate id %0d, id not found %0d, saturated depth %0d",
                 full_seen, dup_seen, miss_seen, sat_seen);
        if (errors == 0 && quote_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d beats never seen", errors, quote_q.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
